>>> hdl/local_peak_window_integrator_defines.svh
// assertion macros for the local peak window integrator
`ifndef LOCAL_PEAK_WINDOW_INTEGRATOR_DEFINES_SVH
`define LOCAL_PEAK_WINDOW_INTEGRATOR_DEFINES_SVH

`ifndef SYNTH
`define LPWI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPWI_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LPWI_ASSERT(lbl, prop, msg)
`define LPWI_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> hdl/lpwi_pkg.sv
// shared constants and types of the local peak window integrator
package lpwi_pkg;

    localparam int MAX_SAMPLES = 128;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + ADDR_W + 1;
    localparam int TSUM_W      = SAMPLE_W - 1 + 2 * ADDR_W;
    localparam int PERIOD_W    = 16;
    localparam int PROD_W      = TSUM_W + PERIOD_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
    localparam int FACTOR_W    = 16;
    localparam int CORR_W      = SUM_W + FACTOR_W + 1;
    localparam int CHARGE_W    = 24;
    localparam int TIME_W      = 20;
    localparam int POS_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int OUT_DATA_W  = 56;
    localparam int WIDTH_W     = 8;
    localparam int SHIFT_W     = 7;
    localparam int PADDR_W     = 5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_POS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SHIFT  = 3'd1;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_APPLY  = 3'd3;
    localparam logic [2:0] REG_GAIN0  = 3'd4;
    localparam logic [2:0] REG_GAIN1  = 3'd5;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_WALK,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

>>> hdl/lpwi_ram.sv
// generic single-port-write, single-port-read ram with registered read
module lpwi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/local_peak_window_integrator.sv
// local peak window integrator: sample store, window walk, scaling and time division
//
// channel  | direction | transaction
// ---------+-----------+----------------------------------------------------
// s_axis   | in        | one waveform sample, gain on tuser, end of pixel on tlast
// m_axis   | out       | one pixel result: charge, time, peak position, status
// apb      | in/out    | configuration register write and read
//
// a sample is taken every cycle while the block loads a pixel
// after the last sample the block walks the window through the sample ram, one
// entry per cycle (read port), then runs the multiply states ST_MUL1 and ST_MUL2
// and a bit-serial division before it takes the next pixel
// rst_n clears the pixel state; the sample ram holds no reset value
// the finished result sits in the output register until taken; a pending
// result does not stall the next pixel until its own result is ready
`include "local_peak_window_integrator_defines.svh"

module local_peak_window_integrator
    import lpwi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  logic                  s_axis_tuser,   // [0] gain_select
    input  logic                  s_axis_tlast,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [23:0] charge, [43:24] pulse_time_q8,
                                                  // [50:44] peak_position, [52:51] status
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // configuration registers
    logic [WIDTH_W-1:0]  window_width_reg;
    logic [SHIFT_W-1:0]  window_shift_reg;
    logic [PERIOD_W-1:0] sample_period_q8_reg;
    logic                apply_correction_reg;
    logic [FACTOR_W-1:0] correction_gain0_q12_reg;
    logic [FACTOR_W-1:0] correction_gain1_q12_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg         <= WIDTH_W'(7);
            window_shift_reg         <= SHIFT_W'(3);
            sample_period_q8_reg     <= PERIOD_W'(256);
            apply_correction_reg     <= 1'b1;
            correction_gain0_q12_reg <= FACTOR_W'(4096);
            correction_gain1_q12_reg <= FACTOR_W'(4096);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  window_width_reg         <= pwdata[WIDTH_W-1:0];
                REG_SHIFT:  window_shift_reg         <= pwdata[SHIFT_W-1:0];
                REG_PERIOD: sample_period_q8_reg     <= pwdata[PERIOD_W-1:0];
                REG_APPLY:  apply_correction_reg     <= pwdata[0];
                REG_GAIN0:  correction_gain0_q12_reg <= pwdata[FACTOR_W-1:0];
                REG_GAIN1:  correction_gain1_q12_reg <= pwdata[FACTOR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_WIDTH:  prdata = 32'(window_width_reg);
            REG_SHIFT:  prdata = 32'(window_shift_reg);
            REG_PERIOD: prdata = 32'(sample_period_q8_reg);
            REG_APPLY:  prdata = 32'(apply_correction_reg);
            REG_GAIN0:  prdata = 32'(correction_gain0_q12_reg);
            REG_GAIN1:  prdata = 32'(correction_gain1_q12_reg);
            default:    prdata = 32'd0;
        endcase
    end

    // control state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;      // stored samples of this pixel
    logic                  ovf_reg, ovf_next;          // more samples than the store holds
    logic signed [SAMPLE_W-1:0] peak_value_reg, peak_value_next;
    logic [ADDR_W-1:0]     peak_at_reg, peak_at_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;          // next window entry to read
    logic                  pv_reg, pv_next;            // ram read data valid
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  m_valid_reg, m_valid_next;

    // datapath registers
    logic                  gain_reg, gain_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]     pidx_reg, pidx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [TSUM_W-1:0]     tsum_reg, tsum_next;
    logic [PROD_W-1:0]     num_reg, num_next;          // product, then quotient
    logic [SUM_W-1:0]      rem_reg, rem_next;
    logic signed [CORR_W-1:0] corr_reg, corr_next;
    logic signed [CHARGE_W-1:0] charge_reg, charge_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // sample ram
    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0]   ram_rdata;

    lpwi_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_axis_tdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // window bounds
    logic signed [CNT_W+1:0] win_start, win_end, win_lo, win_hi;
    logic                    win_empty;

    always_comb
    begin
        win_start = $signed({3'b000, peak_at_reg}) - $signed({3'b000, window_shift_reg});
        win_end   = win_start + $signed({2'b00, window_width_reg});
        win_lo    = win_start[CNT_W+1] ? '0 : win_start;
        win_hi    = (win_end > $signed({2'b00, count_reg})) ?
                    $signed({2'b00, count_reg}) : win_end;
        win_empty = win_hi <= win_lo;
    end

    // arithmetic helpers
    logic s_accept, m_fire;
    logic signed [SAMPLE_W-1:0] s_sample, rd_sample;
    logic [SAMPLE_W+ADDR_W-2:0] term;
    logic [CORR_W-1:0]          corr_mag;
    logic [CORR_W-12-1:0]       corr_round;
    logic signed [CORR_W-11-1:0] corr_signed;
    logic [SUM_W:0]             div_trial;
    logic [FACTOR_W-1:0]        factor;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign m_fire    = m_valid_reg && m_axis_tready;
    assign s_sample  = $signed(s_axis_tdata);
    assign rd_sample = $signed(ram_rdata);
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        peak_value_next = peak_value_reg;
        peak_at_next    = peak_at_reg;
        idx_next        = idx_reg;
        pv_next         = 1'b0;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_fire ? 1'b0 : m_valid_reg;
        gain_next       = gain_reg;
        hi_next         = hi_reg;
        pidx_next       = pidx_reg;
        sum_next        = sum_reg;
        tsum_next       = tsum_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        corr_next       = corr_reg;
        charge_next     = charge_reg;
        time_next       = time_reg;
        status_next     = status_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[ADDR_W-1:0];
        term            = '0;
        factor          = gain_reg ? correction_gain1_q12_reg : correction_gain0_q12_reg;
        corr_mag        = corr_reg[CORR_W-1] ? CORR_W'(-corr_reg) : CORR_W'(corr_reg);
        corr_round      = (CORR_W-12)'((corr_mag + CORR_W'(2048)) >> 12);
        corr_signed     = corr_reg[CORR_W-1] ? -$signed({1'b0, corr_round})
                                             : $signed({1'b0, corr_round});
        div_trial       = {rem_reg, num_reg[PROD_W-1]};

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_accept)
                begin
                    if (count_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (s_sample > peak_value_reg)
                        begin
                            peak_value_next = s_sample;
                            peak_at_next    = count_reg[ADDR_W-1:0];
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        gain_next  = s_axis_tuser;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                sum_next  = '0;
                tsum_next = '0;
                time_next = '0;
                if (ovf_reg || win_empty)
                begin
                    status_next = ovf_reg ? STATUS_OVERFLOW : STATUS_EMPTY;
                    charge_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    status_next = STATUS_OK;
                    idx_next    = win_lo[CNT_W-1:0];
                    hi_next     = win_hi[CNT_W-1:0];
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // read one entry a cycle, accumulate it the cycle after
                if (idx_reg < hi_reg)
                begin
                    ram_re    = 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_sample);
                    if (rd_sample > 0)
                    begin
                        term      = pidx_reg * ram_rdata[SAMPLE_W-2:0];
                        tsum_next = tsum_reg + TSUM_W'(term);
                    end
                end
                else if (idx_reg >= hi_reg)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                num_next  = PROD_W'(tsum_reg * sample_period_q8_reg[7:0]);
                corr_next = sum_reg * $signed({1'b0, factor});
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                num_next = num_reg + (PROD_W'(tsum_reg * sample_period_q8_reg[15:8]) << 8);
                if (!apply_correction_reg)
                begin
                    charge_next = CHARGE_W'(sum_reg);
                end
                else if (corr_signed > $signed((CORR_W-11)'(8388607)))
                begin
                    charge_next = CHARGE_W'(8388607);
                end
                else if (corr_signed < -$signed((CORR_W-11)'(8388608)))
                begin
                    charge_next = CHARGE_W'(-8388608);
                end
                else
                begin
                    charge_next = CHARGE_W'(corr_signed);
                end
                rem_next     = '0;
                div_cnt_next = '0;
                if (sum_reg <= 0)
                begin
                    status_next = STATUS_NOT_POS;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (div_trial >= {1'b0, sum_reg})
                begin
                    rem_next = SUM_W'(div_trial - {1'b0, sum_reg});
                    num_next = {num_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial[SUM_W-1:0];
                    num_next = {num_reg[PROD_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(PROD_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status_reg == STATUS_OK)
                begin
                    time_next = (|num_reg[PROD_W-1:TIME_W]) ? '1 : num_reg[TIME_W-1:0];
                end
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next = OUT_DATA_W'({status_reg, peak_at_reg[POS_W-1:0],
                        ((status_reg == STATUS_OK) ?
                            ((|num_reg[PROD_W-1:TIME_W]) ? {TIME_W{1'b1}} : num_reg[TIME_W-1:0])
                            : time_reg),
                        charge_reg});
                    m_valid_next    = 1'b1;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    peak_value_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
                    peak_at_next    = '0;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            peak_value_reg <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            peak_at_reg    <= '0;
            idx_reg        <= '0;
            pv_reg         <= 1'b0;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            peak_value_reg <= peak_value_next;
            peak_at_reg    <= peak_at_next;
            idx_reg        <= idx_next;
            pv_reg         <= pv_next;
            div_cnt_reg    <= div_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg   <= gain_next;
        hi_reg     <= hi_next;
        pidx_reg   <= pidx_next;
        sum_reg    <= sum_next;
        tsum_reg   <= tsum_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        corr_reg   <= corr_next;
        charge_reg <= charge_next;
        time_reg   <= time_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    `LPWI_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_SAMPLES), "sample count beyond store depth")
    `LPWI_ASSERT(a_ovf_full, ovf_reg |-> count_reg == CNT_W'(MAX_SAMPLES), "overflow without full store")
    `LPWI_ASSERT(a_walk_bound, (state_reg == ST_WALK) |-> (idx_reg <= hi_reg && hi_reg <= count_reg), "window walk out of range")
    `LPWI_ASSERT(a_div_pos, (state_reg == ST_DIV) |-> (sum_reg > 0), "division by non-positive sum")
    `LPWI_ASSERT_NEXT(a_done_load, (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready), m_valid_reg && state_reg == ST_LOAD && count_reg == '0, "result not posted on done")

endmodule

>>> tb/tb_local_peak_window_integrator.sv
// testbench for the local peak window integrator: pixel streams checked against a predictor
module tb_local_peak_window_integrator;
    import lpwi_pkg::*;

    // one expected pixel result
    typedef struct {
        logic [CHARGE_W-1:0] charge;
        logic [TIME_W-1:0]   pulse_time;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
    } pixel_result_t;

    // pixel integration predictor and store of pending pixel results
    class pixel_scoreboard;
        int            waveform[MAX_SAMPLES];
        int            stored_cnt;
        int            peak_val;
        int            peak_idx;
        int            width_cfg;
        int            shift_cfg;
        int            period_cfg;
        bit            apply_cfg;
        int            gain_cfg[2];
        pixel_result_t pending[$];
        int            mismatches;
        int            n_checked;
        int            n_status[4];

        function void reset_state();
            stored_cnt = 0;
            peak_val   = -32768;
            peak_idx   = 0;
            width_cfg  = 7;
            shift_cfg  = 3;
            period_cfg = 256;
            apply_cfg  = 1;
            gain_cfg[0] = 4096;
            gain_cfg[1] = 4096;
        endfunction

        function void set_register(logic [2:0] idx, int value);
            case (idx)
                REG_WIDTH:  width_cfg  = value & 8'hFF;
                REG_SHIFT:  shift_cfg  = value & 7'h7F;
                REG_PERIOD: period_cfg = value & 16'hFFFF;
                REG_APPLY:  apply_cfg  = value[0];
                REG_GAIN0:  gain_cfg[0] = value & 16'hFFFF;
                REG_GAIN1:  gain_cfg[1] = value & 16'hFFFF;
                default: ;
            endcase
        endfunction

        // called for every accepted sample transaction
        function void note_sample(int smp, bit gain, bit is_last);
            pixel_result_t       r;
            longint              start_i, stop_i, lo, hi, acc, prod, mag, rnd, chg;
            longint unsigned     tacc, tq;
            if (stored_cnt < MAX_SAMPLES)
            begin
                waveform[stored_cnt] = smp;
                if (smp > peak_val)
                begin
                    peak_val = smp;
                    peak_idx = stored_cnt;
                end
                stored_cnt++;
            end
            else
                stored_cnt = MAX_SAMPLES + 1;
            if (!is_last)
                return;
            r.charge     = '0;
            r.pulse_time = '0;
            r.position   = peak_idx[POS_W-1:0];
            r.status     = STATUS_OK;
            if (stored_cnt > MAX_SAMPLES)
                r.status = STATUS_OVERFLOW;
            else
            begin
                start_i = longint'(peak_idx) - shift_cfg;
                stop_i  = start_i + width_cfg;
                lo = (start_i < 0) ? 0 : start_i;
                hi = (stop_i > stored_cnt) ? stored_cnt : stop_i;
                if (lo >= hi)
                    r.status = STATUS_EMPTY;
                else
                begin
                    acc  = 0;
                    tacc = 0;
                    for (longint i = lo; i < hi; i++)
                    begin
                        acc += waveform[i];
                        if (waveform[i] > 0)
                            tacc += longint'(i) * waveform[i];
                    end
                    if (acc > 0)
                    begin
                        tq = tacc * longint'(period_cfg) / acc;
                        r.pulse_time = (tq > 1048575) ? 20'hFFFFF : tq[TIME_W-1:0];
                    end
                    else
                        r.status = STATUS_NOT_POS;
                    // q12 scaling, round half away from zero
                    if (apply_cfg)
                    begin
                        prod = acc * gain_cfg[gain];
                        mag  = (prod < 0) ? -prod : prod;
                        rnd  = (mag + 2048) / 4096;
                        chg  = (prod < 0) ? -rnd : rnd;
                    end
                    else
                        chg = acc;
                    if (chg > 8388607)
                        chg = 8388607;
                    if (chg < -8388608)
                        chg = -8388608;
                    r.charge = chg[CHARGE_W-1:0];
                end
            end
            pending.push_back(r);
            stored_cnt = 0;
            peak_val   = -32768;
            peak_idx   = 0;
        endfunction

        function void report(string what, longint exp_v, longint act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
        endfunction

        // called for every accepted result transaction
        function void check_result(logic [OUT_DATA_W-1:0] d);
            pixel_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0h", d);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            n_status[e.status]++;
            if (d[23:0] !== e.charge)      report("charge", e.charge, d[23:0]);
            if (d[43:24] !== e.pulse_time) report("pulse_time", e.pulse_time, d[43:24]);
            if (d[50:44] !== e.position)   report("peak_position", e.position, d[50:44]);
            if (d[52:51] !== e.status)     report("status", e.status, d[52:51]);
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata = '0;   // [15:0] sample
    logic                  s_axis_tuser = 0;    // [0] gain_select
    logic                  s_axis_tlast = 0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [23:0] charge, [43:24] pulse_time_q8,
                                                // [50:44] peak_position, [52:51] status
    logic                  psel = 0;
    logic                  penable = 0;
    logic                  pwrite = 0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    local_peak_window_integrator i_dut (.*);

    localparam int IDLE_LIMIT  = 5000;  // window walk + division + both stalls, many times over
    localparam int SETTLE_WAIT = 300;   // longest pixel processing after the last result

    pixel_scoreboard sb = new();
    int  samples_sent;
    int  pixels_sent;
    int  idle_cycles;
    bit  sample_seen;
    bit  result_seen;
    int  pulse[$];

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // watchdog: cycles with no transaction on either stream
    always @(posedge clk)
    begin
        if (sample_seen || result_seen)
            idle_cycles = 0;
        else
            idle_cycles++;
        sample_seen = 0;
        result_seen = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // gap before a transaction: often none at all, otherwise of random length
    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    // result side: random stall, then take one result transaction
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_gap();
            if (stall > 0)
            begin
                m_axis_tready = 0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            result_seen = 1;
            sb.check_result(m_axis_tdata);
        end
    end

    task automatic write_register(logic [2:0] idx, int value);
        @(negedge clk);
        psel   = 1;
        pwrite = 1;
        paddr  = PADDR_W'(4 * idx);
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    = 0;
        penable = 0;
        pwrite  = 0;
    endtask

    task automatic configure(int width, int shift, int period, int apply_corr, int g0, int g1);
        write_register(REG_WIDTH, width);
        write_register(REG_SHIFT, shift);
        write_register(REG_PERIOD, period);
        write_register(REG_APPLY, apply_corr);
        write_register(REG_GAIN0, g0);
        write_register(REG_GAIN1, g1);
    endtask

    // one sample transaction, valid held across back-to-back items
    task automatic send_sample(int smp, bit gain, bit is_last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata  = smp[15:0];
        s_axis_tuser  = gain;
        s_axis_tlast  = is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sample_seen = 1;
        sb.note_sample(smp, gain, is_last);
        samples_sent++;
        @(negedge clk);
    endtask

    // gain is random on inner samples, the pixel gain goes with the last one
    task automatic send_pixel(bit gain);
        foreach (pulse[i])
            send_sample(pulse[i], (i == pulse.size() - 1) ? gain : bit'($urandom_range(0, 1)),
                        i == pulse.size() - 1);
        s_axis_tvalid = 0;
        pixels_sent++;
        pulse.delete();
    endtask

    // random waveform: mostly a pulse on a noisy baseline, some pure noise
    task automatic make_pixel();
        int len, kind, top, at, sig, v;
        sig = $urandom_range(0, 99);
        if (sig < 5)       len = MAX_SAMPLES;
        else if (sig < 9)  len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6);
        else               len = $urandom_range(1, 24);
        kind = $urandom_range(0, 9);
        top  = (kind == 0) ? 32767 : $urandom_range(1, 30000);
        at   = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++)
        begin
            if (kind < 6)
            begin
                // triangular pulse around the peak
                v = top - (top / 3) * ((i > at) ? i - at : at - i);
                if (v < 0)
                    v = 0;
                v = v + $urandom_range(0, 40) - 20;
            end
            else if (kind < 8)
                v = $urandom_range(0, 65535) - 32768;
            else
                v = -$urandom_range(0, 32768);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            pulse.push_back(v);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        sb.reset_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed pixels at reset settings: extremes, sign, ties, zero sum
        pulse = '{32767};                send_pixel(0);
        pulse = '{-32768};               send_pixel(1);
        pulse = '{0};                    send_pixel(0);
        pulse = '{-5, -3, -7};           send_pixel(1);
        pulse = '{1, 9, 9, 2};           send_pixel(0);
        pulse = '{10, 200, 900, 400, 80, 5, -2}; send_pixel(1);
        drain();

        // widest window, heavy gain scaling, zero gain factor
        configure(128, 0, 65535, 1, 65535, 0);
        pulse = '{32767, 32767, 32767, 32767}; send_pixel(0);
        pulse = '{-32768, -32768, -32768};     send_pixel(0);
        pulse = '{100, 30000, 200};            send_pixel(1);
        drain();

        // narrowest window far before the peak: empty window, no correction
        configure(1, 127, 1, 0, 0, 65535);
        pulse = '{3, 5, 1};                    send_pixel(0);
        pulse = '{-1, -2};                     send_pixel(1);
        drain();

        // random settings per phase, extremes mixed in
        while (samples_sent < 1550)
        begin
            configure(($urandom_range(0, 4) == 0) ? 128 : $urandom_range(1, 20),
                      ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(0, 10),
                      ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 2000),
                      $urandom_range(0, 1),
                      ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 8192),
                      ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8192));
            repeat ($urandom_range(4, 14))
            begin
                make_pixel();
                send_pixel($urandom_range(0, 1));
            end
            drain();
        end

        drain();
        $display("%0d samples in %0d pixels, %0d results checked", samples_sent, pixels_sent,
                 sb.n_checked);
        $display("status ok %0d, not positive %0d, empty %0d, overflow %0d",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> local_peak_window_integrator.f
+incdir+hdl
hdl/lpwi_pkg.sv
hdl/lpwi_ram.sv
hdl/local_peak_window_integrator.sv
tb/tb_local_peak_window_integrator.sv
